// ===== rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB pair finder package
// Shared types and codes for the slot table, sequencer and result items.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // Operation codes carried by func
  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_SCAN   = 2'd2,
    FN_MOVE   = 2'd3
  } func_t;

  // Result codes carried by kind
  typedef enum logic [1:0] {
    RES_DONE = 2'd0,
    RES_PAIR = 2'd1,
    RES_FULL = 2'd2,
    RES_NUSE = 2'd3
  } res_kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_LOAD,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Stored rectangle
  typedef struct packed {
    logic [14:0] h;
    logic [14:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  localparam int MASK_REGS = 4;

endpackage

// ===== rtl/aabb_collision_pair_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB collision pair finder
// Slot table of typed boxes with add, remove, move and pairwise scan.
// ----------------------------------------------------------------------------
// Timing: remove and move give their item through the response state and the
//   output register; add walks the valid bits one slot a cycle from slot 0.
// Scan: one table read per cycle through the shared compare unit, unless the
//   output side stalls; slot i is compared with slots i+1 to SLOTS-1.
// One input item at a time; the next is taken once the final result is queued.
// Reset (rst, synchronous): all slots free, masks zero, no item pending.
//   Table contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
module aabb_collision_pair_finder
  import aabb_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [5:0]  slot,
  input  logic [3:0]  obj_type,
  input  logic [15:0] box_x,
  input  logic [15:0] box_y,
  input  logic [14:0] box_w,
  input  logic [14:0] box_h,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [5:0]  slot_a,
  output logic [5:0]  slot_b,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = SLOT_W + 1;

  // Strict overlap on both axes; 18-bit sums cannot wrap.
  function automatic logic boxes_overlap(box_t a, box_t b);
    logic signed [17:0] ax, ay, aw, ah, bx, by, bw, bh;
    ax = {{2{a.x[15]}}, a.x};
    ay = {{2{a.y[15]}}, a.y};
    aw = {3'b000, a.w};
    ah = {3'b000, a.h};
    bx = {{2{b.x[15]}}, b.x};
    by = {{2{b.y[15]}}, b.y};
    bw = {3'b000, b.w};
    bh = {3'b000, b.h};
    return (ax < bx + bw) && (bx < ax + aw) && (ay < by + bh) && (by < ay + ah);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: four 64-bit pair enable registers at 8-byte spacing.
  // Row r lives in register r/4, bit (r mod 4)*16 + second type.
  // --------------------------------------------------------------------------
  logic [63:0] mask [MASK_REGS];

  assign pready = 1'b1;
  assign prdata = mask[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MASK_REGS; r++) begin
        mask[r] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      mask[paddr[4:3]] <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Slot table: valid bits in flops, type and box in a one-port memory with
  // registered read. The read register holds while the scan is stalled.
  // --------------------------------------------------------------------------
  logic [SLOTS-1:0]  used, used_next;
  logic [3:0]        mem_kind [SLOTS];
  box_t              mem_box  [SLOTS];
  logic [3:0]        rd_kind;
  box_t              rd_box;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              we_kind, we_box;
  logic [SLOT_W-1:0] wr_addr;
  logic [3:0]        wr_kind;
  box_t              wr_box;

  always_ff @(posedge clk) begin
    if (we_kind) begin
      mem_kind[wr_addr] <= wr_kind;
    end
    if (we_box) begin
      mem_box[wr_addr] <= wr_box;
    end
    if (rd_en) begin
      rd_kind <= mem_kind[rd_addr];
      rd_box  <= mem_box[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t            state, state_next;
  logic [CNT_W-1:0]  k, k_next;           // add search / scan issue pointer
  logic              cv, cv_next;         // rd_* holds a scan candidate
  logic [SLOT_W-1:0] ck, ck_next;         // slot of that candidate
  logic [SLOT_W-1:0] idx_i, idx_i_next;   // scanned slot
  logic [3:0]        kind_i, kind_i_next;
  box_t              box_i, box_i_next;
  logic              pend, pend_next;     // a pair found, not yet sent
  logic [SLOT_W-1:0] pend_k, pend_k_next;
  logic [3:0]        hold_kind, hold_kind_next;
  box_t              hold_box, hold_box_next;
  res_kind_t         res_kind, res_kind_next;
  logic [5:0]        res_a, res_a_next;
  logic [5:0]        res_b, res_b_next;

  // output register
  logic              out_valid_next;
  logic [1:0]        kind_next;
  logic [5:0]        slot_a_next, slot_b_next;
  logic              last_next;

  // Decode of the request
  box_t              in_box;
  logic [SLOT_W-1:0] in_si;
  logic              in_used;
  logic              out_free;

  // Scan compare unit
  logic              hit;
  logic              stall;

  assign in_box   = '{h: box_h, w: box_w, y: box_y, x: box_x};
  assign in_si    = slot[SLOT_W-1:0];
  assign in_used  = (7'(slot) < 7'(SLOTS)) && used[in_si];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  assign hit = used[ck] && mask[kind_i[3:2]][{kind_i[1:0], rd_kind}] &&
               boxes_overlap(box_i, rd_box);
  // A new pair pushes the held one out; wait if the output register is busy.
  assign stall = cv && hit && pend && !out_free;

  always_comb begin
    state_next     = state;
    used_next      = used;
    k_next         = k;
    cv_next        = cv;
    ck_next        = ck;
    idx_i_next     = idx_i;
    kind_i_next    = kind_i;
    box_i_next     = box_i;
    pend_next      = pend;
    pend_k_next    = pend_k;
    hold_kind_next = hold_kind;
    hold_box_next  = hold_box;
    res_kind_next  = res_kind;
    res_a_next     = res_a;
    res_b_next     = res_b;
    out_valid_next = out_valid && !out_ready;
    kind_next      = kind;
    slot_a_next    = slot_a;
    slot_b_next    = slot_b;
    last_next      = last;
    rd_en          = 1'b0;
    rd_addr        = k[SLOT_W-1:0];
    we_kind        = 1'b0;
    we_box         = 1'b0;
    wr_addr        = in_si;
    wr_kind        = hold_kind;
    wr_box         = in_box;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_b_next = '0;
          if (func_t'(func) == FN_ADD) begin
            hold_kind_next = obj_type;
            hold_box_next  = in_box;
            k_next         = '0;
            state_next     = ST_ADD;
          end else if (!in_used) begin
            res_kind_next = RES_NUSE;
            res_a_next    = slot;
            state_next    = ST_RESP;
          end else begin
            res_kind_next = RES_DONE;
            res_a_next    = 6'(in_si);
            case (func_t'(func))
              FN_REMOVE: begin
                used_next[in_si] = 1'b0;
                state_next       = ST_RESP;
              end
              FN_MOVE: begin
                we_box     = 1'b1;
                state_next = ST_RESP;
              end
              default: begin
                // scan: fetch slot i first
                rd_en      = 1'b1;
                rd_addr    = in_si;
                idx_i_next = in_si;
                state_next = ST_LOAD;
              end
            endcase
          end
        end
      end

      ST_ADD: begin
        // lowest free slot, one valid bit per cycle
        res_b_next = '0;
        if (!used[k[SLOT_W-1:0]]) begin
          used_next[k[SLOT_W-1:0]] = 1'b1;
          we_kind       = 1'b1;
          we_box        = 1'b1;
          wr_addr       = k[SLOT_W-1:0];
          wr_box        = hold_box;
          res_kind_next = RES_DONE;
          res_a_next    = 6'(k[SLOT_W-1:0]);
          state_next    = ST_RESP;
        end else if (k[SLOT_W-1:0] == SLOT_W'(SLOTS - 1)) begin
          res_kind_next = RES_FULL;
          res_a_next    = '0;
          state_next    = ST_RESP;
        end else begin
          k_next = k + 1'b1;
        end
      end

      ST_LOAD: begin
        kind_i_next = rd_kind;
        box_i_next  = rd_box;
        k_next      = CNT_W'({1'b0, idx_i}) + 1'b1;
        cv_next     = 1'b0;
        pend_next   = 1'b0;
        state_next  = ST_SCAN;
      end

      ST_SCAN: begin
        if (!stall) begin
          // compare stage
          if (cv && hit) begin
            if (pend) begin
              out_valid_next = 1'b1;
              kind_next      = RES_PAIR;
              slot_a_next    = 6'(idx_i);
              slot_b_next    = 6'(pend_k);
              last_next      = 1'b0;
            end
            pend_next   = 1'b1;
            pend_k_next = ck;
          end
          // issue stage
          if (k != CNT_W'(SLOTS)) begin
            rd_en   = 1'b1;
            cv_next = 1'b1;
            ck_next = k[SLOT_W-1:0];
            k_next  = k + 1'b1;
          end else begin
            cv_next = 1'b0;
            if (!cv) begin
              // table exhausted: held pair, or a plain done, is the last item
              res_kind_next = pend ? RES_PAIR : RES_DONE;
              res_a_next    = 6'(idx_i);
              res_b_next    = pend ? 6'(pend_k) : 6'd0;
              pend_next     = 1'b0;
              state_next    = ST_RESP;
            end
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          kind_next      = res_kind;
          slot_a_next    = res_a;
          slot_b_next    = res_b;
          last_next      = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      cv        <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      cv        <= cv_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    ck        <= ck_next;
    idx_i     <= idx_i_next;
    kind_i    <= kind_i_next;
    box_i     <= box_i_next;
    pend_k    <= pend_k_next;
    hold_kind <= hold_kind_next;
    hold_box  <= hold_box_next;
    res_kind  <= res_kind_next;
    res_a     <= res_a_next;
    res_b     <= res_b_next;
    kind      <= kind_next;
    slot_a    <= slot_a_next;
    slot_b    <= slot_b_next;
    last      <= last_next;
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == RES_PAIR) |-> (slot_a < slot_b))
    else $error("pair item with slot_a not below slot_b");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != RES_PAIR) |-> last && (slot_b == 6'd0))
    else $error("non-pair item not final or with nonzero slot_b");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend && !cv)
    else $error("scan state left over in idle");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> (state == ST_SCAN) && cv && $stable(ck) && $stable(k))
    else $error("scan pointer moved during a stall");
`endif

endmodule
